@@ src/lslp_pkg.sv @@
// package with constants and types for the scan line parser
package lslp_pkg;

  localparam int RX_W     = 8;
  localparam int RANGE_W  = 13;
  localparam int HDR_W    = 6;
  localparam int IDX_W    = 8;
  localparam int SIX_W    = 6;
  localparam int CODE_W   = 2 * SIX_W;

  localparam int POINTS   = 228;

  localparam logic [RX_W-1:0]    CH_G     = 8'h47;
  localparam logic [RX_W-1:0]    CH_LF    = 8'h0a;
  localparam logic [RX_W-1:0]    CH_ZERO  = 8'h30;

  localparam logic [CODE_W-1:0]  CODE_ERR_A = 12'd0;
  localparam logic [CODE_W-1:0]  CODE_ERR_B = 12'd6;
  localparam logic [CODE_W-1:0]  CODE_FAR   = 12'd16;
  localparam logic [RANGE_W-1:0] FAR_MM     = 13'd4096;

  localparam logic [RANGE_W-1:0] MAX_READING_RESET   = 13'd5700;
  localparam logic [HDR_W-1:0]   HEADER_LENGTH_RESET = 6'd12;
  localparam logic [HDR_W-1:0]   HDR_SAT             = 6'd63;
  localparam logic [IDX_W-1:0]   IDX_LAST            = IDX_W'(POINTS - 1);

  typedef enum logic [0:0] {
    REG_MAX_READING   = 1'b0,
    REG_HEADER_LENGTH = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    KIND_SAMPLE = 1'b0,
    KIND_END    = 1'b1
  } kind_t;

endpackage

@@ src/ladar_scan_line_parser_core.sv @@
// scan line parser top level: two-character distance decoder
//
// input channel: one received serial character per beat on in_rx_byte,
// handshake in_valid / in_ready. result channel: one beat per decoded
// distance (out_kind sample) or per frame end (out_kind end), handshake
// out_valid / out_ready. configuration: cfg_we writes cfg_wdata into the
// register picked by cfg_index (0 max reading, 1 header length).
// the parser waits for 'G', skips the header, then turns each character
// pair into a 12-bit code; two line feeds in a row close the frame and
// flip the ping-pong bank.
// a result is registered and appears on the port in the cycle after the
// beat that completes it. one character per cycle unless out_ready stalls,
// set by the single output register that the parse state feeds.
// reset (synchronous, rst_n low) returns to waiting for 'G', bank 0,
// registers to their defaults, and empties the output register.
// when the receiver stalls, the pending result holds and in_ready drops
// until it is taken.
module ladar_scan_line_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lslp_pkg::RX_W-1:0]     in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [lslp_pkg::RANGE_W-1:0]  out_range_mm,
  output logic [lslp_pkg::IDX_W-1:0]    out_point_index,
  output logic                          out_bank,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [lslp_pkg::RANGE_W-1:0]  cfg_wdata
);
  import lslp_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_G = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_SPARE  = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [HDR_W-1:0]    hdr_cnt_r, hdr_cnt_nxt;
  logic                await_hi_r, await_hi_nxt;
  logic [SIX_W-1:0]    hi_part_r, hi_part_nxt;
  logic [1:0]          lf_run_r, lf_run_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                bank_r, bank_nxt;
  logic [RANGE_W-1:0]  max_rd_r;
  logic [HDR_W-1:0]    hdr_len_r;

  logic                out_valid_r;
  logic                kind_r, kind_nxt;
  logic [RANGE_W-1:0]  range_r, range_nxt;
  logic [IDX_W-1:0]    pidx_r, pidx_nxt;
  logic                obank_r, obank_nxt;
  logic                emit;

  logic                accept;
  logic [RX_W-1:0]     diff;
  logic [SIX_W-1:0]    six;
  logic [CODE_W-1:0]   code;
  logic [RANGE_W-1:0]  dist_mm;
  logic [HDR_W-1:0]    hdr_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign diff = in_rx_byte - CH_ZERO;
  assign six  = diff[SIX_W-1:0];
  assign code = {hi_part_r, six};
  assign hdr_inc = (hdr_cnt_r < HDR_SAT) ? hdr_cnt_r + 1'b1 : hdr_cnt_r;

  always_comb begin
    if (code == CODE_ERR_A || code == CODE_ERR_B) begin
      dist_mm = max_rd_r;
    end else if (code == CODE_FAR) begin
      dist_mm = FAR_MM;
    end else begin
      dist_mm = {{(RANGE_W-CODE_W){1'b0}}, code};
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    await_hi_nxt = await_hi_r;
    hi_part_nxt  = hi_part_r;
    lf_run_nxt   = lf_run_r;
    idx_nxt      = idx_r;
    bank_nxt     = bank_r;
    emit         = 1'b0;
    kind_nxt     = KIND_SAMPLE;
    range_nxt    = '0;
    pidx_nxt     = '0;
    obank_nxt    = bank_r;
    case (phase_r)
      PH_WAIT_G: begin
        if (in_rx_byte == CH_G) begin
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = HDR_W'(1);
        end
      end
      PH_HEADER: begin
        hdr_cnt_nxt = hdr_inc;
        if (hdr_inc >= hdr_len_r) begin
          phase_nxt    = PH_DATA;
          await_hi_nxt = 1'b1;
          idx_nxt      = '0;
        end
      end
      PH_DATA: begin
        if (in_rx_byte == CH_LF) begin
          if (lf_run_r != 2'd3) begin
            lf_run_nxt = lf_run_r + 2'd1;
          end
        end else begin
          lf_run_nxt = 2'd0;
          if (await_hi_r) begin
            hi_part_nxt  = six;
            await_hi_nxt = 1'b0;
          end else begin
            emit         = 1'b1;
            kind_nxt     = KIND_SAMPLE;
            range_nxt    = dist_mm;
            pidx_nxt     = idx_r;
            idx_nxt      = (idx_r >= IDX_LAST) ? '0 : idx_r + 1'b1;
            await_hi_nxt = 1'b1;
          end
        end
        if (lf_run_nxt == 2'd2) begin
          emit       = 1'b1;
          kind_nxt   = KIND_END;
          range_nxt  = '0;
          pidx_nxt   = '0;
          bank_nxt   = !bank_r;
          phase_nxt  = PH_WAIT_G;
          lf_run_nxt = 2'd0;
        end
      end
      default: begin
        phase_nxt = PH_WAIT_G;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_G;
      hdr_cnt_r   <= '0;
      await_hi_r  <= 1'b1;
      hi_part_r   <= '0;
      lf_run_r    <= 2'd0;
      idx_r       <= '0;
      bank_r      <= 1'b0;
      max_rd_r    <= MAX_READING_RESET;
      hdr_len_r   <= HEADER_LENGTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_READING:   max_rd_r  <= cfg_wdata;
          REG_HEADER_LENGTH: hdr_len_r <= cfg_wdata[HDR_W-1:0];
          default:           ;
        endcase
      end
      if (accept) begin
        phase_r    <= phase_nxt;
        hdr_cnt_r  <= hdr_cnt_nxt;
        await_hi_r <= await_hi_nxt;
        hi_part_r  <= hi_part_nxt;
        lf_run_r   <= lf_run_nxt;
        idx_r      <= idx_nxt;
        bank_r     <= bank_nxt;
      end
      if (in_ready) begin
        out_valid_r <= accept && emit;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r  <= kind_nxt;
      range_r <= range_nxt;
      pidx_r  <= pidx_nxt;
      obank_r <= obank_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_range_mm    = range_r;
  assign out_point_index = pidx_r;
  assign out_bank        = obank_r;

endmodule
